// File: hdl/hsp_pkg.sv
// hsp_pkg: shared types and constants of the hierarchical scope profiler
// command and status codes, controller states and port widths
// no dependencies
package hsp_pkg;

  localparam int unsigned IDX_W     = 12;
  localparam int unsigned TICK_W    = 64;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 320;

  localparam int unsigned DEF_ANCHOR_COUNT = 4096;
  localparam int unsigned DEF_STACK_DEPTH  = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENTER = 2'd0,
    CMD_EXIT  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_EXEC,
    S_EXIT_RD,
    S_UPDATE,
    S_READ
  } state_e;

endpackage

// File: hdl/hsp_ram.sv
// hsp_ram: simple dual-port synchronous ram, one write and one read port
// read data is registered and appears in the cycle after a read with re_i high
// no dependencies
module hsp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/hierarchical_scope_profiler.sv
// hierarchical_scope_profiler: top level, scope stack and per-anchor tick counters
// depends on hsp_pkg and hsp_ram
//
// channel  dir  handshake            tuser           tdata
// s        in   s_tvalid/s_tready    command         anchor_index, timestamp
// m        out  m_tvalid/m_tready    status          elapsed, inclusive, child,
//                                                    exclusive, hit_count
//
// enter and an exit on an empty stack finish in S_EXEC; a read goes on through
// S_READ, and an exit through S_EXIT_RD to read the stack ram and S_UPDATE for
// the read-modify-write of the counter rams
// when ANCHOR_COUNT is not a power of two and below 4096, the index is reduced
// one bit a cycle in S_REDUCE before every item is executed
// after reset a clearing pass over all ANCHOR_COUNT entries zeroes the counter
// rams, s_tready stays low meanwhile
// a result waits in the output register; the next item is accepted meanwhile
// and stalls at its last step only while that register is still full
module hierarchical_scope_profiler #(
  parameter int unsigned ANCHOR_COUNT = hsp_pkg::DEF_ANCHOR_COUNT,
  parameter int unsigned STACK_DEPTH  = hsp_pkg::DEF_STACK_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [hsp_pkg::CMD_W-1:0]     s_tuser_i,  // command
  input  logic [hsp_pkg::S_TDATA_W-1:0] s_tdata_i,  // anchor_index, timestamp, zero pad
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [hsp_pkg::STATUS_W-1:0]  m_tuser_o,  // status
  output logic [hsp_pkg::M_TDATA_W-1:0] m_tdata_o   // elapsed_ticks, inclusive_ticks,
                                                    // child_ticks, exclusive_ticks,
                                                    // hit_count
);

  import hsp_pkg::*;

  localparam int unsigned AW       = $clog2(ANCHOR_COUNT);
  localparam int unsigned CW       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SPW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned STEP_W   = $clog2(IDX_W);
  localparam int unsigned FRAME_W  = TICK_W + 2 * AW;
  localparam int unsigned ENTRY_W  = 2 * TICK_W;
  localparam bit          NEED_MOD = (ANCHOR_COUNT < (1 << IDX_W)) &&
                                     ((ANCHOR_COUNT & (ANCHOR_COUNT - 1)) != 0);
  localparam logic [AW-1:0]     CLR_LAST  = AW'(ANCHOR_COUNT - 1);
  localparam logic [AW:0]       MOD_N     = (AW + 1)'(ANCHOR_COUNT);
  localparam logic [CW-1:0]     FC_FULL   = CW'(STACK_DEPTH);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(IDX_W - 1);

  state_e              state_q, state_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [TICK_W-1:0]   ts_q, ts_d;
  logic [AW-1:0]       slot_q, slot_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [CW-1:0]       fc_q, fc_d;
  logic [AW-1:0]       cur_q, cur_d;
  logic [AW-1:0]       anc_q, anc_d;
  logic [AW-1:0]       par_q, par_d;
  logic [TICK_W-1:0]   ticks_q, ticks_d;
  logic [AW-1:0]       clr_q, clr_d;

  logic                m_valid_q, m_valid_d;
  logic [STATUS_W-1:0] m_status_q;
  logic [TICK_W-1:0]   m_elapsed_q, m_incl_q, m_child_q, m_excl_q, m_hits_q;

  logic                load_res;
  logic [STATUS_W-1:0] res_status;
  logic [TICK_W-1:0]   res_elapsed, res_incl, res_child, res_hits;
  logic                out_free;
  logic                s_accept;

  logic [AW:0]         red_sum;
  logic [AW:0]         red_diff;

  logic                stk_we, stk_re;
  logic [SPW-1:0]      stk_waddr, stk_raddr;
  logic [FRAME_W-1:0]  stk_wdata, stk_rdata;
  logic [CW-1:0]       fc_dec;

  logic                a_we, a_re, b_we, b_re;
  logic [AW-1:0]       a_waddr, a_raddr, b_waddr, b_raddr;
  logic [ENTRY_W-1:0]  a_wdata, a_rdata;
  logic [TICK_W-1:0]   b_wdata, b_rdata;

  logic [TICK_W-1:0]   frame_start;
  logic [AW-1:0]       frame_anchor, frame_parent;

  assign s_tready_o = (state_q == S_IDLE);
  assign s_accept   = s_tvalid_i && s_tready_o;
  assign out_free   = !m_valid_q || m_tready_i;

  assign red_sum  = {slot_q, idx_q[IDX_W-1]};
  assign red_diff = red_sum - MOD_N;
  assign fc_dec   = fc_q - CW'(1);

  assign frame_start  = stk_rdata[TICK_W-1:0];
  assign frame_anchor = stk_rdata[TICK_W +: AW];
  assign frame_parent = stk_rdata[TICK_W + AW +: AW];

  // frame stack: {parent, anchor, start}
  hsp_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (STACK_DEPTH),
    .ADDR_W(SPW)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // anchor counters: {hits, inclusive}
  hsp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ANCHOR_COUNT),
    .ADDR_W(AW)
  ) u_incl (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(a_waddr),
    .wdata_i(a_wdata),
    .re_i   (a_re),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  // anchor children totals
  hsp_ram #(
    .WIDTH (TICK_W),
    .DEPTH (ANCHOR_COUNT),
    .ADDR_W(AW)
  ) u_child (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(b_waddr),
    .wdata_i(b_wdata),
    .re_i   (b_re),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    ts_d     = ts_q;
    slot_d   = slot_q;
    step_d   = step_q;
    fc_d     = fc_q;
    cur_d    = cur_q;
    anc_d    = anc_q;
    par_d    = par_q;
    ticks_d  = ticks_q;
    clr_d    = clr_q;

    load_res    = 1'b0;
    res_status  = STATUS_OK;
    res_elapsed = '0;
    res_incl    = '0;
    res_child   = '0;
    res_hits    = '0;

    stk_we    = 1'b0;
    stk_waddr = fc_q[SPW-1:0];
    stk_wdata = {cur_q, slot_q, ts_q};
    stk_re    = 1'b0;
    stk_raddr = fc_dec[SPW-1:0];

    a_we    = 1'b0;
    a_waddr = anc_q;
    a_wdata = {a_rdata[ENTRY_W-1:TICK_W] + TICK_W'(1), a_rdata[TICK_W-1:0] + ticks_q};
    a_re    = 1'b0;
    a_raddr = slot_q;
    b_we    = 1'b0;
    b_waddr = par_q;
    b_wdata = b_rdata + ticks_q;
    b_re    = 1'b0;
    b_raddr = slot_q;

    unique case (state_q)
      S_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr_q;
        a_wdata = '0;
        b_we    = 1'b1;
        b_waddr = clr_q;
        b_wdata = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_accept) begin
          cmd_d   = s_tuser_i;
          idx_d   = s_tdata_i[IDX_W-1:0];
          ts_d    = s_tdata_i[IDX_W +: TICK_W];
          step_d  = '0;
          if (NEED_MOD) begin
            slot_d  = '0;
            state_d = S_REDUCE;
          end else begin
            slot_d  = AW'(s_tdata_i[IDX_W-1:0]);
            state_d = S_EXEC;
          end
        end
      end
      S_REDUCE: begin
        // restoring remainder, one index bit per cycle, msb first
        if (red_sum >= MOD_N) begin
          slot_d = AW'(red_diff);
        end else begin
          slot_d = AW'(red_sum);
        end
        idx_d  = idx_q << 1;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_q)
          CMD_ENTER: begin
            if (out_free) begin
              load_res = 1'b1;
              state_d  = S_IDLE;
              if (fc_q == FC_FULL) begin
                res_status = STATUS_OVERFLOW;
              end else begin
                stk_we = 1'b1;
                fc_d   = fc_q + CW'(1);
                cur_d  = slot_q;
              end
            end
          end
          CMD_EXIT: begin
            if (fc_q == '0) begin
              if (out_free) begin
                load_res   = 1'b1;
                res_status = STATUS_UNDERFLOW;
                state_d    = S_IDLE;
              end
            end else begin
              stk_re  = 1'b1;
              fc_d    = fc_dec;
              state_d = S_EXIT_RD;
            end
          end
          CMD_READ: begin
            a_re    = 1'b1;
            b_re    = 1'b1;
            state_d = S_READ;
          end
          default: begin
            if (out_free) begin
              load_res = 1'b1;
              state_d  = S_IDLE;
            end
          end
        endcase
      end
      S_EXIT_RD: begin
        ticks_d = ts_q - frame_start;
        anc_d   = frame_anchor;
        par_d   = frame_parent;
        cur_d   = frame_parent;
        a_re    = 1'b1;
        a_raddr = frame_anchor;
        b_re    = 1'b1;
        b_raddr = frame_parent;
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) begin
          a_we        = 1'b1;
          b_we        = (par_q != anc_q);
          load_res    = 1'b1;
          res_elapsed = ticks_q;
          state_d     = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          load_res  = 1'b1;
          res_incl  = a_rdata[TICK_W-1:0];
          res_child = b_rdata;
          res_hits  = a_rdata[ENTRY_W-1:TICK_W];
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (load_res) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      fc_q      <= '0;
      cur_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      fc_q      <= fc_d;
      cur_q     <= cur_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    ts_q    <= ts_d;
    slot_q  <= slot_d;
    step_q  <= step_d;
    anc_q   <= anc_d;
    par_q   <= par_d;
    ticks_q <= ticks_d;
    if (load_res) begin
      m_status_q  <= res_status;
      m_elapsed_q <= res_elapsed;
      m_incl_q    <= res_incl;
      m_child_q   <= res_child;
      m_excl_q    <= res_incl - res_child;
      m_hits_q    <= res_hits;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = m_status_q;
  assign m_tdata_o  = {m_hits_q, m_excl_q, m_child_q, m_incl_q, m_elapsed_q};

  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= FC_FULL)
    else $error("frame count beyond stack depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_res |-> (!m_valid_q || m_tready_i))
    else $error("result loaded over an untaken result");

  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cmd_q == CMD_EXIT && fc_q != '0)
      |=> (fc_q == $past(fc_q) - CW'(1)) && (state_q == S_EXIT_RD))
    else $error("exit did not pop one frame");

  a_no_clear_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_tready_o && !load_res)
    else $error("activity during clearing pass");

endmodule
